// ===== rtl/pli_pkg.sv =====
`timescale 1ns / 1ps

package pli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int DATA_W     = 32;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int DIV_STEPS  = PROD_W / 2;   // two quotient bits per cycle
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_FLAT = 2'd2;

	typedef struct packed {
		logic               action;
		logic [5:0]         point_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] query_u;
	} pli_in_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic [1:0]         status;
	} pli_out_t;

	typedef enum logic [1:0] {
		RD_MID = 2'd0,
		RD_LO  = 2'd1,
		RD_HI  = 2'd2
	} pli_rd_sel_t;

	typedef struct packed {
		logic        write;
		logic        start;
		pli_rd_sel_t rd_sel;
		logic        step;
		logic        take_lo;
		logic        take_hi;
		logic        diff;
		logic        mul;
		logic        div_step;
		logic        load_out;
	} pli_cmd_t;

	typedef struct packed {
		logic search_done;
		logic div_last;
		logic flat;
	} pli_sts_t;

endpackage

// ===== rtl/pli_ram.sv =====
`timescale 1ns / 1ps

module pli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/pli_ctrl.sv =====
`timescale 1ns / 1ps

module pli_ctrl import pli_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     in_action,
	output logic     out_valid,
	input  logic     out_ready,
	output pli_cmd_t cmd,
	input  pli_sts_t sts
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SCHECK = 9'b000000010,
		S_SWAIT  = 9'b000000100,
		S_GETLO  = 9'b000001000,
		S_GETHI  = 9'b000010000,
		S_DIFF   = 9'b000100000,
		S_MUL    = 9'b001000000,
		S_DIV    = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.rd_sel = RD_MID;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action == ACT_LOAD) begin
						cmd.write = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = S_SCHECK;
					end
				end
			end
			S_SCHECK: begin
				if (sts.search_done) begin
					cmd.rd_sel = RD_LO;
					state_d    = S_GETLO;
				end else begin
					cmd.rd_sel = RD_MID;
					state_d    = S_SWAIT;
				end
			end
			S_SWAIT: begin
				cmd.step = 1'b1;
				state_d  = S_SCHECK;
			end
			S_GETLO: begin
				cmd.take_lo = 1'b1;
				cmd.rd_sel  = RD_HI;
				state_d     = S_GETHI;
			end
			S_GETHI: begin
				cmd.take_hi = 1'b1;
				state_d     = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = sts.flat ? S_FIN : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/pli_dp.sv =====
`timescale 1ns / 1ps

module pli_dp import pli_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	input  pli_in_t          in_data,
	input  pli_cmd_t         cmd,
	output pli_sts_t         sts,
	output pli_out_t         out_data
);

	logic [CNT_W-1:0]       points_q;
	logic [CNT_W-1:0]       count;
	logic [ADDR_W-1:0]      lo_q, hi_q, mid, raddr;
	logic [CNT_W-1:0]       mid_sum;
	logic [ADDR_W-1:0]      span;
	logic signed [31:0]     u_q, xl_q, yl_q, xh_q, yh_q;
	logic [2*DATA_W-1:0]    rdata;
	logic signed [31:0]     rd_x, rd_y;
	logic signed [32:0]     dy, du, dx;
	logic [31:0]            mag_dy_q, mag_du_q, mag_dx_q;
	logic                   neg_q, flat_q;
	logic [PROD_W-1:0]      n_q, n1, n2;
	logic [31:0]            rem_q, r1, r2;
	logic [32:0]            t1, t2;
	logic                   b1, b2;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic                   big;
	logic signed [34:0]     qm, tq;
	logic signed [35:0]     sum;
	logic                   ovf_hi, ovf_lo;
	pli_out_t               res;

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] a;
		a = v[32] ? 33'(-v) : v;
		return a[31:0];
	endfunction

	// count clamped to [2, MAX_POINTS]
	always_comb begin
		if (points_q < CNT_W'(2)) begin
			count = CNT_W'(2);
		end else if (points_q > CNT_W'(MAX_POINTS)) begin
			count = CNT_W'(MAX_POINTS);
		end else begin
			count = points_q;
		end
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[ADDR_W:1];
	assign span    = hi_q - lo_q;

	always_comb begin
		case (cmd.rd_sel)
			RD_LO:   raddr = lo_q;
			RD_HI:   raddr = hi_q;
			default: raddr = mid;
		endcase
	end

	pli_ram #(
		.WIDTH(2 * DATA_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (in_data.point_index),
		.wdata ({in_data.point_x, in_data.point_y}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_x = rdata[2*DATA_W-1:DATA_W];
	assign rd_y = rdata[DATA_W-1:0];

	assign dy = {yh_q[31], yh_q} - {yl_q[31], yl_q};
	assign du = {u_q[31], u_q} - {xl_q[31], xl_q};
	assign dx = {xh_q[31], xh_q} - {xl_q[31], xl_q};

	// restoring divider, two quotient bits per cycle
	always_comb begin
		t1 = {rem_q, n_q[PROD_W-1]};
		b1 = t1 >= {1'b0, mag_dx_q};
		r1 = b1 ? 32'(t1 - {1'b0, mag_dx_q}) : t1[31:0];
		n1 = {n_q[PROD_W-2:0], b1};
		t2 = {r1, n1[PROD_W-1]};
		b2 = t2 >= {1'b0, mag_dx_q};
		r2 = b2 ? 32'(t2 - {1'b0, mag_dx_q}) : t2[31:0];
		n2 = {n1[PROD_W-2:0], b2};
	end

	// quotient beyond 2^33 always saturates
	assign big    = n_q > 64'h0000_0002_0000_0000;
	assign qm     = {1'b0, n_q[33:0]};
	assign tq     = neg_q ? -qm : qm;
	assign sum    = {{4{yl_q[31]}}, yl_q} + {tq[34], tq};
	assign ovf_hi = !sum[35] && (sum[34:31] != 4'h0);
	assign ovf_lo = sum[35] && (sum[34:31] != 4'hF);

	always_comb begin
		if (flat_q) begin
			res.interp_value = yl_q;
			res.status       = ST_FLAT;
		end else if (big) begin
			res.interp_value = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			res.status       = ST_SAT;
		end else if (ovf_hi) begin
			res.interp_value = 32'sh7FFF_FFFF;
			res.status       = ST_SAT;
		end else if (ovf_lo) begin
			res.interp_value = 32'sh8000_0000;
			res.status       = ST_SAT;
		end else begin
			res.interp_value = sum[31:0];
			res.status       = ST_OK;
		end
	end

	assign sts.search_done = span <= ADDR_W'(1);
	assign sts.div_last    = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign sts.flat        = flat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= CNT_W'(2);
		end else if (cfg_valid) begin
			points_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			u_q  <= in_data.query_u;
			lo_q <= '0;
			hi_q <= ADDR_W'(count - CNT_W'(1));
		end else if (cmd.step) begin
			if (rd_x > u_q) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid;
			end
		end
		if (cmd.take_lo) begin
			xl_q <= rd_x;
			yl_q <= rd_y;
		end
		if (cmd.take_hi) begin
			xh_q <= rd_x;
			yh_q <= rd_y;
		end
		if (cmd.diff) begin
			mag_dy_q <= mag33(dy);
			mag_du_q <= mag33(du);
			mag_dx_q <= mag33(dx);
			neg_q    <= (dy[32] ^ du[32]) ^ dx[32];
			flat_q   <= xh_q == xl_q;
		end
		if (cmd.mul) begin
			n_q       <= mag_dy_q * mag_du_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			n_q       <= n2;
			rem_q     <= r2;
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
		if (cmd.load_out) begin
			out_data <= res;
		end
	end

endmodule

// ===== rtl/piecewise_linear_interpolator.sv =====
`timescale 1ns / 1ps
// Piecewise linear interpolator over a table of up to 64 (x, y) breakpoints, Q16.16.
// Input channel in_valid/in_ready/in_data: a load item (action = load) writes
// point_x/point_y into slot point_index and gives no result; a query item gives
// one result on out_valid/out_ready/out_data (interp_value, status).
// Config channel cfg_valid/cfg_ready/cfg_data sets the points in use (reset 2);
// cfg_ready is always high; write it only while the block is idle.
// Operation: loads are taken back to back while idle. A query occupies the block
// through its steps: the accepting cycle, a check and a wait state per search
// step on the single table read port, then reading the end points and forming
// differences, one 32x32 multiply, then a two-bit-per-cycle restoring divider
// (skipped for a zero-width segment), and saturation into the output register.
// A finished result waits in the output register; loads keep being taken
// meanwhile, and the next query only stalls at its last cycle until the
// receiver takes the previous result.
// Reset clears the controller and sets the points in use to 2; table contents
// are undefined until loaded, and no query may read an unloaded slot.
module piecewise_linear_interpolator import pli_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  pli_in_t          in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output pli_out_t         out_data
);

	pli_cmd_t cmd;
	pli_sts_t sts;

	assign cfg_ready = 1'b1;

	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_action (in_data.action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pli_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

	// a load item never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.action == ACT_LOAD && !out_valid) |=> !out_valid)
		else $error("result appeared after a load item");

	// a query blocks the input until it finishes
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.action == ACT_QUERY) |=> !in_ready)
		else $error("input taken while a query is in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_OK || out_data.status == ST_SAT ||
			out_data.status == ST_FLAT))
		else $error("undefined status code");

	// write enable only while idle, so table reads never race a load
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> (in_ready && in_valid))
		else $error("table write outside an accepted load");

endmodule

// ===== test/pli_result_checker.sv =====
`timescale 1ns / 1ps

module pli_result_checker import pli_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  pli_in_t          in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  pli_out_t         out_data,
	output int               mismatch_count,
	output int               pending_results
);

	localparam longint          SAT_HI    = 64'sd2147483647;
	localparam longint          SAT_LO    = -64'sd2147483648;
	localparam longint unsigned FORCE_SAT = 64'h2_0000_0000;

	logic signed [31:0] tab_x [MAX_POINTS];
	logic signed [31:0] tab_y [MAX_POINTS];
	logic [CNT_W-1:0]   points_cfg = CNT_W'(2);
	pli_out_t           expected_results [$];
	int                 errors = 0;

	function automatic longint unsigned mag(input longint a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic pli_out_t predict_query(input logic signed [31:0] u);
		int                lo, hi, mid, n;
		longint            xl, xh, yl, yh, dy, du, dx, s;
		longint unsigned   num, q;
		logic              neg;
		pli_out_t          r;
		n = points_cfg;
		if (n < 2)
			n = 2;
		if (n > MAX_POINTS)
			n = MAX_POINTS;
		lo = 0;
		hi = n - 1;
		while (hi - lo > 1) begin
			mid = (hi + lo) / 2;
			if (tab_x[mid] > u)
				hi = mid;
			else
				lo = mid;
		end
		xl = tab_x[lo];
		xh = tab_x[hi];
		yl = tab_y[lo];
		yh = tab_y[hi];
		r.status = ST_OK;
		if (xh == xl) begin
			s = yl;
			r.status = ST_FLAT;
		end else begin
			dy  = yh - yl;
			du  = u - xl;
			dx  = xh - xl;
			neg = ((dy < 0) != (du < 0)) != (dx < 0);
			num = mag(dy) * mag(du);
			q   = num / mag(dx);
			// quotient far out of range: push past the bound so it saturates
			if (q > FORCE_SAT)
				s = neg ? SAT_LO - 1 : SAT_HI + 1;
			else
				s = neg ? yl - $signed(q) : yl + $signed(q);
			if (s > SAT_HI) begin
				s = SAT_HI;
				r.status = ST_SAT;
			end else if (s < SAT_LO) begin
				s = SAT_LO;
				r.status = ST_SAT;
			end
		end
		r.interp_value = s[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pli_out_t want;
		if (!arst_n) begin
			points_cfg = CNT_W'(2);
			expected_results.delete();
			errors = 0;
			mismatch_count  <= 0;
			pending_results <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				points_cfg = cfg_data;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result item: value %h status %0d",
							out_data.interp_value, out_data.status);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.interp_value !== want.interp_value ||
							out_data.status !== want.status) begin
						if (errors < 10)
							$display("mismatch: expected value %h status %0d, got value %h status %0d",
								want.interp_value, want.status,
								out_data.interp_value, out_data.status);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.action == ACT_LOAD) begin
					tab_x[in_data.point_index] = in_data.point_x;
					tab_y[in_data.point_index] = in_data.point_y;
				end else begin
					expected_results.push_back(predict_query(in_data.query_u));
				end
			end
			mismatch_count  <= errors;
			pending_results <= expected_results.size();
		end
	end

endmodule

// ===== test/piecewise_linear_interpolator_tb.sv =====
`timescale 1ns / 1ps

module piecewise_linear_interpolator_tb;
	import pli_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 64;
	localparam int ITEM_GOAL      = 550;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	pli_in_t          in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	pli_out_t         out_data;

	int   in_idle_pct  = 32;
	int   out_idle_pct = 69;
	logic hold_req     = 1'b0;
	int   mismatches;
	int   pending;
	int   items_sent   = 0;
	int   n_active     = 2;

	// stimulus-side copy of breakpoint abscissae, used to aim queries
	logic signed [31:0] bp_x [MAX_POINTS];

	always #5 clk = ~clk;

	piecewise_linear_interpolator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	pli_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.mismatch_count  (mismatches),
		.pending_results (pending)
	);

	initial begin : receiver
		int   hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("piecewise_linear_interpolator_tb failed");
		$finish;
	end

	task automatic send(input pli_in_t it);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic load_point(input int slot, input logic signed [31:0] x,
			input logic signed [31:0] y);
		pli_in_t it;
		it.action      = ACT_LOAD;
		it.point_index = 6'(slot);
		it.point_x     = x;
		it.point_y     = y;
		it.query_u     = $urandom;
		bp_x[slot] = x;
		send(it);
	endtask

	task automatic query(input logic signed [31:0] u);
		pli_in_t it;
		it.action      = ACT_QUERY;
		it.point_index = 6'($urandom);
		it.point_x     = $urandom;
		it.point_y     = $urandom;
		it.query_u     = u;
		send(it);
	endtask

	// drain: every expected result in, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_points(input logic [CNT_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		n_active = (v < 2) ? 2 : (v > MAX_POINTS) ? MAX_POINTS : int'(v);
	endtask

	// reload every slot in use: mostly ascending, some with repeats, some unordered
	task automatic fill_table(input int n);
		int                 mode;
		logic               big_y;
		longint             xv;
		logic signed [31:0] xw, yv;
		mode  = $urandom_range(99);
		big_y = $urandom_range(1);
		xv    = longint'($signed($urandom)) >>> 1;
		for (int i = 0; i < n; i++) begin
			xw = (mode < 85) ? xv[31:0] : $urandom;
			yv = big_y ? $urandom : ($signed($urandom) >>> 7);
			load_point(i, xw, yv);
			if (!(mode >= 70 && mode < 85 && $urandom_range(2) == 0))
				xv += $urandom_range(1 << 24, 1);
		end
	endtask

	function automatic logic signed [31:0] pick_u();
		int     r;
		longint base;
		r    = $urandom_range(99);
		base = bp_x[$urandom_range(n_active - 1)];
		if (r < 15)
			return base[31:0];
		if (r < 60)
			return 32'(base + longint'($urandom_range(1 << 20)) - (1 << 19));
		if (r < 90)
			return $urandom;
		case ($urandom_range(3))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh0000_0000;
			default: return 32'shFFFF_FFFF;
		endcase
	endfunction

	initial begin : stimulus
		int               seg, nq, r;
		logic [CNT_W-1:0] cv;
		logic             pressure_done;
		seg = 0;
		pressure_done = 1'b0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two points in use after reset
		load_point(0, 32'sh0000_0000, 32'sh0000_0000);
		load_point(1, 32'sh0001_0000, 32'sh000A_0000);
		query(32'sh0000_8000);
		query(32'sh8000_0000);
		query(32'sh7FFF_FFFF);
		// full-range segment
		load_point(0, 32'sh8000_0000, 32'sh8000_0000);
		load_point(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		query(32'sh0000_0000);
		query(32'sh8000_0000);
		query(32'sh7FFF_FFFF);
		// zero-width segment
		load_point(1, 32'sh8000_0000, 32'sh1234_5678);
		query(32'sh0000_1000);
		// steep slope, saturates both ways
		load_point(0, 32'sh0000_0000, 32'sh7FFF_FFFF);
		load_point(1, 32'sh0000_0001, 32'sh8000_0000);
		query(32'sh0000_0005);
		query(-32'sh0000_0003);
		// descending table
		load_point(0, 32'sh0000_0064, 32'sh0010_0000);
		load_point(1, -32'sh0000_0064, -32'sh0010_0000);
		query(32'sh0000_0000);
		query(32'sh0000_00C8);
		load_point(63, 32'sh7FFF_FFFF, 32'sh8000_0000);

		items_sent = 0;
		while (items_sent < ITEM_GOAL) begin
			if (items_sent >= 2 * ITEM_GOAL / 3) begin
				in_idle_pct  = 0;
				out_idle_pct = 0;
			end else if (items_sent >= ITEM_GOAL / 3) begin
				in_idle_pct  = 69;
				out_idle_pct = 32;
			end
			case (seg)
				0: cv = CNT_W'(0);
				1: cv = CNT_W'(1);
				2: cv = CNT_W'(127);
				3: cv = CNT_W'(64);
				4: cv = CNT_W'(3);
				default: begin
					r = $urandom_range(99);
					if (r < 70)
						cv = CNT_W'($urandom_range(9, 2));
					else if (r < 90)
						cv = CNT_W'($urandom_range(64, 10));
					else
						cv = CNT_W'($urandom_range(127, 65));
				end
			endcase
			set_points(cv);
			fill_table(n_active);
			if (!pressure_done && in_idle_pct == 0) begin
				// receiver stalls long while queries keep coming
				hold_req <= 1'b1;
				pressure_done = 1'b1;
				repeat (12)
					query(pick_u());
			end
			nq = $urandom_range(30, 8);
			repeat (nq) begin
				r = $urandom_range(99);
				if (r < 85)
					query(pick_u());
				else if (r < 95)
					load_point($urandom_range(n_active - 1), $urandom, $urandom);
				else
					load_point($urandom_range(MAX_POINTS - 1), $urandom, $urandom);
			end
			seg++;
		end

		settle();
		if (mismatches == 0 && pending == 0)
			$display("piecewise_linear_interpolator_tb passed");
		else
			$display("piecewise_linear_interpolator_tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pli_pkg.sv
rtl/pli_ram.sv
rtl/pli_ctrl.sv
rtl/pli_dp.sv
rtl/piecewise_linear_interpolator.sv
test/pli_result_checker.sv
test/piecewise_linear_interpolator_tb.sv
